// File: sv/tnd_pkg.sv
// Shared types, constants and codes of the trie node decoder.
package tnd_pkg;

   localparam int unsigned MEM_BYTES_DEFAULT   = 1048576;
   localparam int unsigned MAX_ENTRIES_DEFAULT = 63;

   localparam int POS_W   = 21;   // node positions and addresses
   localparam int NODE_W  = 20;   // reported positions
   localparam int COUNT_W = 32;

   // header byte classes
   localparam logic [7:0] HDR_SINGLE_LO = 8'h20;
   localparam logic [7:0] HDR_SINGLE_HI = 8'h80;
   localparam logic [7:0] HDR_OFF1_HI   = 8'hA0;
   localparam logic [7:0] HDR_CNT2_LO   = 8'hC0;
   localparam logic [7:0] HDR_CNT4_LO   = 8'hE0;
   localparam logic [7:0] HDR_K_MASK    = 8'h1F;

   localparam logic [63:0] OFF_NONE_1 = 64'd255;
   localparam logic [63:0] OFF_NONE_2 = 64'd65535;
   localparam logic [63:0] OFF_NONE_8 = '1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef enum logic [2:0] {
      ERR_OK         = 3'd0,
      ERR_BAD_NODE   = 3'd1,
      ERR_NEED_NEXT  = 3'd2,
      ERR_NEED_COUNT = 3'd3,
      ERR_BAD_SIZE   = 3'd4,
      ERR_BAD_COUNT  = 3'd5,
      ERR_BAD_OFFSET = 3'd6
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HDR_RD, ST_HDR, ST_KCNT_RD, ST_KCNT, ST_SIZE,
      ST_SYM_RD, ST_SYM, ST_CNT_RD, ST_CNT, ST_OFF_RD, ST_OFF,
      ST_EMIT, ST_FINAL
   } state_type;

   typedef struct packed {
      logic                       is_choice;
      logic [7:0]                 symbol;
      logic signed [COUNT_W-1:0]  choice_count;
      logic                       next_none;
      logic [NODE_W-1:0]          next_node;
      logic signed [COUNT_W-1:0]  remaining_count;
      logic                       last;
      err_type                    error_code;
      logic [NODE_W-1:0]          error_position;
   } rsp_item_type;

endpackage

// File: sv/tnd_if.sv
// Request and response channel interfaces of the trie node decoder.
interface tnd_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [20:0]        address;
   logic [7:0]         write_data;
   logic               node_none;
   logic signed [31:0] running_count;
   logic signed [7:0]  min_symbol;
   logic signed [7:0]  max_symbol;

   modport source (output valid, operation, address, write_data, node_none,
                   running_count, min_symbol, max_symbol, input ready);
   modport sink   (input valid, operation, address, write_data, node_none,
                   running_count, min_symbol, max_symbol, output ready);
endinterface

interface tnd_rsp_if;
   logic               valid;
   logic               ready;
   logic               is_choice;
   logic [7:0]         symbol;
   logic signed [31:0] choice_count;
   logic               next_none;
   logic [19:0]        next_node;
   logic signed [31:0] remaining_count;
   logic               last;
   logic [2:0]         error_code;
   logic [19:0]        error_position;

   modport source (output valid, is_choice, symbol, choice_count, next_none,
                   next_node, remaining_count, last, error_code, error_position,
                   input ready);
   modport sink   (input valid, is_choice, symbol, choice_count, next_none,
                   next_node, remaining_count, last, error_code, error_position,
                   output ready);
endinterface

// File: sv/tnd_ram.sv
// Generic single-port RAM with registered read.
module tnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;
endmodule

// File: sv/trie_node_decoder.sv
// Top level of the trie node decoder: sequencer around the index byte memory.
//
// Usage
//   req_bus carries one transaction per item. operation = write stores
//   write_data at address (addresses at or above MEM_BYTES are dropped) and
//   gives no response. operation = decode walks the node ending at address
//   and returns zero or more entry transactions (is_choice = 1) followed by
//   one summary transaction (last = 1) with the remaining count and error.
//   csr_write_enable / csr_write_data load index_length; write it while idle.
// Timing
//   A decode reads the memory one byte at a time through the single RAM
//   port, each byte as an address state, then the registered read data:
//   the header, the extended count if any, a size check, then for each
//   entry its symbol, and for an entry in range its count and offset bytes
//   and the entry response; then the summary. The RAM port sets the rate.
//   req_bus.ready is high only between decodes.
// Reset
//   Synchronous active-high reset clears the sequencer, the response valid
//   and index_length; memory contents are undefined until written.
// Backpressure
//   Responses sit in an output register; the sequencer stalls on an entry
//   or summary while that register is full and not being taken.
module trie_node_decoder
   import tnd_pkg::*;
#(
   parameter int unsigned MEM_BYTES   = MEM_BYTES_DEFAULT,
   parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   tnd_req_if.sink          req_bus,
   tnd_rsp_if.source        rsp_bus,
   input  logic             csr_write_enable,
   input  logic [POS_W-1:0] csr_write_data
);
   localparam int AW = $clog2(MEM_BYTES);

   state_type            state_ff, state_in;
   logic [POS_W-1:0]     index_length_ff;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [31:0]          count_ff, count_in;
   logic signed [7:0]    min_ff, min_in, max_ff, max_in;
   logic [2:0]           cs_ff, cs_in;      // count bytes: 1, 2 or 4
   logic [3:0]           os_ff, os_in;      // offset bytes: 0, 1, 2 or 8
   logic [7:0]           k_ff, k_in;
   logic [5:0]           e_ff, e_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     ent_ff, ent_in;
   logic [31:0]          c_ff, c_in;
   logic [63:0]          off_ff, off_in;
   logic [2:0]           j_ff, j_in;
   logic [7:0]           sym_ff, sym_in;
   logic                 nnone_ff, nnone_in;
   logic [NODE_W-1:0]    nnode_ff, nnode_in;
   logic                 single_ff, single_in;
   err_type              err_ff, err_in;
   logic [NODE_W-1:0]    epos_ff, epos_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_addr;
   logic [7:0]           ram_rdata;
   logic                 out_free;
   logic                 req_take;
   logic [3:0]           size;
   logic [11:0]          ksz;
   logic [31:0]          c_lane;
   logic [63:0]          off_lane;
   logic                 in_range;

   tnd_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (req_bus.write_data),
      .read_data    (ram_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign ram_we        = req_take && (req_bus.operation == OP_WRITE)
                          && (32'(req_bus.address) < 32'(MEM_BYTES));
   assign ram_addr      = (state_ff == ST_IDLE) ? AW'(req_bus.address) : AW'(pos_ff);

   assign size     = 4'd1 + 4'(cs_ff) + os_ff;
   assign ksz      = 12'(k_ff) * 12'(size);
   assign in_range = ($signed(ram_rdata) >= min_ff) && ($signed(ram_rdata) <= max_ff);

   always_comb begin
      c_lane   = c_ff;
      c_lane[{j_ff[1:0], 3'b000} +: 8] = ram_rdata;
      off_lane = off_ff;
      off_lane[{j_ff, 3'b000} +: 8] = ram_rdata;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      cs_in        = cs_ff;
      os_in        = os_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      start_in     = start_ff;
      ent_in       = ent_ff;
      c_in         = c_ff;
      off_in       = off_ff;
      j_in         = j_ff;
      sym_in       = sym_ff;
      nnone_in     = nnone_ff;
      nnode_in     = nnode_ff;
      single_in    = single_ff;
      err_in       = err_ff;
      epos_in      = epos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.operation == OP_DECODE) begin
               count_in  = req_bus.running_count;
               min_in    = req_bus.min_symbol;
               max_in    = req_bus.max_symbol;
               err_in    = ERR_OK;
               epos_in   = '0;
               single_in = 1'b0;
               if (req_bus.node_none) begin
                  state_in = ST_FINAL;
               end else if (req_bus.address == '0
                            || req_bus.address > index_length_ff
                            || 32'(req_bus.address) > 32'(MEM_BYTES)) begin
                  err_in   = ERR_BAD_NODE;
                  epos_in  = req_bus.address[NODE_W-1:0];
                  state_in = ST_FINAL;
               end else begin
                  pos_in   = req_bus.address - POS_W'(1);
                  state_in = ST_HDR_RD;
               end
            end
         end
         ST_HDR_RD: state_in = ST_HDR;
         ST_HDR: begin
            if (ram_rdata >= HDR_SINGLE_LO && ram_rdata < HDR_SINGLE_HI) begin
               if (pos_ff == '0) begin
                  err_in   = ERR_NEED_NEXT;
                  epos_in  = '0;
                  state_in = ST_FINAL;
               end else if (in_range) begin
                  single_in = 1'b1;
                  sym_in    = ram_rdata;
                  c_in      = count_ff;
                  nnone_in  = 1'b0;
                  nnode_in  = pos_ff[NODE_W-1:0];
                  state_in  = ST_EMIT;
               end else begin
                  count_in = '0;
                  state_in = ST_FINAL;
               end
            end else begin
               cs_in = (ram_rdata < HDR_CNT2_LO) ? 3'd1 :
                       (ram_rdata < HDR_CNT4_LO) ? 3'd2 : 3'd4;
               os_in = (ram_rdata < HDR_SINGLE_LO) ? 4'd0 :
                       (ram_rdata < HDR_OFF1_HI)   ? 4'd1 :
                       (ram_rdata < HDR_CNT4_LO)   ? 4'd2 : 4'd8;
               k_in  = ram_rdata & HDR_K_MASK;
               if ((ram_rdata & HDR_K_MASK) == '0) begin
                  if (pos_ff == '0) begin
                     err_in   = ERR_NEED_COUNT;
                     epos_in  = '0;
                     state_in = ST_FINAL;
                  end else begin
                     pos_in   = pos_ff - POS_W'(1);
                     state_in = ST_KCNT_RD;
                  end
               end else begin
                  state_in = ST_SIZE;
               end
            end
         end
         ST_KCNT_RD: state_in = ST_KCNT;
         ST_KCNT: begin
            k_in     = ram_rdata;
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            if (k_ff == '0 || k_ff > 8'(MAX_ENTRIES) || pos_ff < POS_W'(ksz)) begin
               err_in   = ERR_BAD_SIZE;
               epos_in  = pos_ff[NODE_W-1:0];
               state_in = ST_FINAL;
            end else begin
               start_in = pos_ff - POS_W'(ksz);
               pos_in   = pos_ff - POS_W'(ksz);
               e_in     = '0;
               state_in = ST_SYM_RD;
            end
         end
         ST_SYM_RD: state_in = ST_SYM;
         ST_SYM: begin
            sym_in = ram_rdata;
            ent_in = pos_ff;
            if (in_range) begin
               pos_in   = pos_ff + POS_W'(1);
               j_in     = '0;
               c_in     = '0;
               state_in = ST_CNT_RD;
            end else begin
               pos_in = pos_ff + POS_W'(size);
               e_in   = e_ff + 6'd1;
               if ({2'b00, e_ff} + 8'd1 == k_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_SYM_RD;
               end
            end
         end
         ST_CNT_RD: state_in = ST_CNT;
         ST_CNT: begin
            c_in   = c_lane;
            pos_in = pos_ff + POS_W'(1);
            j_in   = j_ff + 3'd1;
            if (j_ff + 3'd1 == cs_ff) begin
               if (c_lane == '0 || c_lane[31]) begin
                  err_in   = ERR_BAD_COUNT;
                  epos_in  = NODE_W'(ent_ff + POS_W'(1));
                  state_in = ST_FINAL;
               end else if (os_ff == '0) begin
                  nnone_in = 1'b1;
                  nnode_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  j_in     = '0;
                  off_in   = '0;
                  state_in = ST_OFF_RD;
               end
            end else begin
               state_in = ST_CNT_RD;
            end
         end
         ST_OFF_RD: state_in = ST_OFF;
         ST_OFF: begin
            off_in = off_lane;
            pos_in = pos_ff + POS_W'(1);
            j_in   = j_ff + 3'd1;
            if (4'(j_ff) + 4'd1 == os_ff) begin
               if ((os_ff == 4'd1 && off_lane == OFF_NONE_1)
                   || (os_ff == 4'd2 && off_lane == OFF_NONE_2)
                   || (os_ff == 4'd8 && off_lane == OFF_NONE_8)) begin
                  nnone_in = 1'b1;
                  nnode_in = '0;
                  state_in = ST_EMIT;
               end else if ((|off_lane[63:POS_W]) || off_lane[POS_W-1:0] > start_ff) begin
                  err_in   = ERR_BAD_OFFSET;
                  epos_in  = NODE_W'(ent_ff + POS_W'(1) + POS_W'(cs_ff));
                  state_in = ST_FINAL;
               end else begin
                  nnone_in = 1'b0;
                  nnode_in = NODE_W'(start_ff - off_lane[POS_W-1:0]);
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_OFF_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.is_choice       = 1'b1;
               rsp_in.symbol          = sym_ff;
               rsp_in.choice_count    = c_ff;
               rsp_in.next_none       = nnone_ff;
               rsp_in.next_node       = nnode_ff;
               rsp_in.remaining_count = '0;
               rsp_in.last            = 1'b0;
               rsp_in.error_code      = ERR_OK;
               rsp_in.error_position  = '0;
               if (single_ff) begin
                  count_in = '0;
                  state_in = ST_FINAL;
               end else begin
                  count_in = count_ff - c_ff;
                  e_in     = e_ff + 6'd1;
                  if ({2'b00, e_ff} + 8'd1 == k_ff) begin
                     state_in = ST_FINAL;
                  end else begin
                     state_in = ST_SYM_RD;
                  end
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.is_choice       = 1'b0;
               rsp_in.symbol          = '0;
               rsp_in.choice_count    = '0;
               rsp_in.next_none       = 1'b0;
               rsp_in.next_node       = '0;
               rsp_in.remaining_count = count_ff;
               rsp_in.last            = 1'b1;
               rsp_in.error_code      = err_ff;
               rsp_in.error_position  = epos_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         index_length_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            index_length_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      cs_ff     <= cs_in;
      os_ff     <= os_in;
      k_ff      <= k_in;
      e_ff      <= e_in;
      start_ff  <= start_in;
      ent_ff    <= ent_in;
      c_ff      <= c_in;
      off_ff    <= off_in;
      j_ff      <= j_in;
      sym_ff    <= sym_in;
      nnone_ff  <= nnone_in;
      nnode_ff  <= nnode_in;
      single_ff <= single_in;
      err_ff    <= err_in;
      epos_ff   <= epos_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.is_choice       = rsp_ff.is_choice;
   assign rsp_bus.symbol          = rsp_ff.symbol;
   assign rsp_bus.choice_count    = rsp_ff.choice_count;
   assign rsp_bus.next_none       = rsp_ff.next_none;
   assign rsp_bus.next_node       = rsp_ff.next_node;
   assign rsp_bus.remaining_count = rsp_ff.remaining_count;
   assign rsp_bus.last            = rsp_ff.last;
   assign rsp_bus.error_code      = rsp_ff.error_code;
   assign rsp_bus.error_position  = rsp_ff.error_position;

   // entry loop never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYM || state_ff == ST_SYM_RD) |-> ({2'b00, e_ff} < k_ff))
      else $error("entry index past entry count");

   // count byte counter stays inside the count field
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CNT) |-> (j_ff < cs_ff && (cs_ff == 3'd1 || cs_ff == 3'd2
                                                 || cs_ff == 3'd4)))
      else $error("count byte counter out of field");

   // offset bytes are only read when the node has offsets
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OFF) |-> (os_ff != '0 && 4'(j_ff) < os_ff))
      else $error("offset byte read outside offset field");

   // entry transactions never carry an error or a last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_choice) |-> (!rsp_ff.last && rsp_ff.error_code == ERR_OK))
      else $error("entry transaction marked last or errored");

   // a new response is only loaded when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(rsp_ff))
      else $error("pending response overwritten");
endmodule

// File: verif/tnd_checker.sv
// Checker: watches the trie node decoder channels, predicts responses and compares them.
module tnd_checker
   import tnd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tnd_req_if          req_bus,
   tnd_rsp_if          rsp_bus,
   input  logic        csr_write_enable,
   input  logic [20:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]   node_bytes [bit [19:0]];
   logic [20:0]  valid_length;
   rsp_item_type expected_rsps[$];

   function automatic logic [7:0] byte_at(logic [63:0] pos);
      if (pos < MEM_BYTES_DEFAULT && node_bytes.exists(pos[19:0])) return node_bytes[pos[19:0]];
      return 8'h00;
   endfunction

   function automatic logic [63:0] le_at(logic [63:0] pos, int nbytes);
      logic [63:0] v;
      v = '0;
      for (int j = 0; j < nbytes; j++) v |= 64'(byte_at(pos + j)) << (8 * j);
      return v;
   endfunction

   task automatic push_entry(logic [7:0] sym, logic [31:0] cnt, logic nn, logic [63:0] nd);
      rsp_item_type r;
      r = '0;
      r.is_choice = 1'b1;
      r.symbol = sym;
      r.choice_count = cnt;
      r.next_none = nn;
      r.next_node = nd[19:0];
      expected_rsps = {expected_rsps, r};
   endtask

   task automatic push_summary(logic [31:0] rem, err_type err, logic [63:0] pos);
      rsp_item_type r;
      r = '0;
      r.remaining_count = rem;
      r.last = 1'b1;
      r.error_code = err;
      r.error_position = (err == ERR_OK) ? 20'd0 : pos[19:0];
      expected_rsps = {expected_rsps, r};
   endtask

   // Walk one node and queue every response it yields.
   task automatic predict_decode(logic [20:0] addr, logic none, logic [31:0] count_in,
                                 logic signed [7:0] lo, logic signed [7:0] hi);
      logic [63:0] n, hdr, k, esize, start, p, off;
      logic [31:0] cnt, c;
      int cw, ow;
      logic signed [7:0] s;
      logic has_child;
      cnt = count_in;
      if (none) begin
         push_summary(cnt, ERR_OK, 0);
         return;
      end
      n = addr;
      if (n < 1 || n > valid_length || n > MEM_BYTES_DEFAULT) begin
         push_summary(cnt, ERR_BAD_NODE, addr);
         return;
      end
      n--;
      hdr = byte_at(n);
      if (hdr >= HDR_SINGLE_LO && hdr < HDR_SINGLE_HI) begin
         if (n < 1) begin
            push_summary(cnt, ERR_NEED_NEXT, n);
            return;
         end
         s = hdr[7:0];
         if (s >= lo && s <= hi) push_entry(hdr[7:0], cnt, 1'b0, n);
         push_summary(0, ERR_OK, 0);
         return;
      end
      cw = (hdr < HDR_CNT2_LO) ? 1 : (hdr < HDR_CNT4_LO) ? 2 : 4;
      ow = (hdr < HDR_SINGLE_LO) ? 0 : (hdr < HDR_OFF1_HI) ? 1 : (hdr < HDR_CNT4_LO) ? 2 : 8;
      k = hdr & HDR_K_MASK;
      if (k == 0) begin
         if (n < 1) begin
            push_summary(cnt, ERR_NEED_COUNT, n);
            return;
         end
         n--;
         k = byte_at(n);
      end
      esize = cw + ow + 1;
      if (k == 0 || k > MAX_ENTRIES_DEFAULT || n < k * esize) begin
         push_summary(cnt, ERR_BAD_SIZE, n);
         return;
      end
      start = n - k * esize;
      for (int e = 0; e < k; e++) begin
         p = start + e * esize;
         s = byte_at(p);
         if (s < lo || s > hi) continue;
         c = le_at(p + 1, cw);
         if (c == 0 || c[31]) begin
            push_summary(cnt, ERR_BAD_COUNT, p + 1);
            return;
         end
         has_child = 1'b0;
         off = 0;
         if (ow != 0) begin
            off = le_at(p + 1 + cw, ow);
            if (!((ow == 1 && off == OFF_NONE_1) || (ow == 2 && off == OFF_NONE_2) ||
                  (ow == 8 && off == OFF_NONE_8))) begin
               if (off > start) begin
                  push_summary(cnt, ERR_BAD_OFFSET, p + 1 + cw);
                  return;
               end
               has_child = 1'b1;
            end
         end
         push_entry(byte_at(p), c, !has_child, has_child ? start - off : 64'd0);
         cnt -= c;
      end
      push_summary(cnt, ERR_OK, 0);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type got, want;
      if (reset) begin
         valid_length <= '0;
         fail_count = 0;
         rsp_seen = 0;
      end else begin
         if (csr_write_enable) valid_length <= csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.operation == OP_WRITE) begin
               if (req_bus.address < MEM_BYTES_DEFAULT)
                  node_bytes[req_bus.address[19:0]] = req_bus.write_data;
            end else
               predict_decode(req_bus.address, req_bus.node_none, req_bus.running_count,
                              req_bus.min_symbol, req_bus.max_symbol);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            got = '0;
            got.is_choice = rsp_bus.is_choice;
            got.symbol = rsp_bus.symbol;
            got.choice_count = rsp_bus.choice_count;
            got.next_none = rsp_bus.next_none;
            got.next_node = rsp_bus.next_node;
            got.remaining_count = rsp_bus.remaining_count;
            got.last = rsp_bus.last;
            got.error_code = err_type'(rsp_bus.error_code);
            got.error_position = rsp_bus.error_position;
            if (expected_rsps.size() == 0) begin
               $display("unexpected transaction at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.is_choice !== want.is_choice) report("is_choice", got.is_choice, want.is_choice);
               if (got.symbol !== want.symbol) report("symbol", got.symbol, want.symbol);
               if (got.choice_count !== want.choice_count)
                  report("choice_count", got.choice_count, want.choice_count);
               if (got.next_none !== want.next_none) report("next_none", got.next_none, want.next_none);
               if (got.next_node !== want.next_node) report("next_node", got.next_node, want.next_node);
               if (got.remaining_count !== want.remaining_count)
                  report("remaining_count", got.remaining_count, want.remaining_count);
               if (got.last !== want.last) report("last", got.last, want.last);
               if (got.error_code !== want.error_code)
                  report("error_code", got.error_code, want.error_code);
               if (got.error_position !== want.error_position)
                  report("error_position", got.error_position, want.error_position);
            end
         end
      end
      pending_count = expected_rsps.size();
   end
endmodule

// File: verif/trie_node_decoder_tb.sv
// Testbench top: builds trie nodes in memory, decodes them and gives the verdict.
module trie_node_decoder_tb;
   import tnd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [20:0] csr_write_data = '0;
   int          fail_count, pending_count, rsp_seen;
   int          decodes_sent = 0;
   int          writes_sent = 0;

   tnd_req_if req_bus ();
   tnd_rsp_if rsp_bus ();

   // Memory is filled contiguously from 0; decodes only target regions that
   // were fully written so no unwritten byte is ever read.
   logic [20:0] node_ends[$];
   logic [20:0] fill_ptr = 21'd0;  // next free byte
   logic [20:0] valid_length;

   always #5 clock = ~clock;

   trie_node_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   tnd_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .rsp_seen         (rsp_seen)
   );

   // Gap length: mostly zero or short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sink side stalls; a stretch with no stalling now and then.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else if (gap_len() == 0)
            rsp_bus.ready <= 1'b1;
         else begin
            rsp_bus.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // One transaction on the request channel; waits for the handshake.
   task automatic send(logic op, logic [20:0] addr, logic [7:0] data, logic none,
                       logic [31:0] cnt, logic [7:0] lo, logic [7:0] hi);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.address <= addr;
      req_bus.write_data <= data;
      req_bus.node_none <= none;
      req_bus.running_count <= cnt;
      req_bus.min_symbol <= lo;
      req_bus.max_symbol <= hi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == OP_WRITE) writes_sent++;
      else decodes_sent++;
   endtask

   task automatic drop_valid();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic put_byte(logic [7:0] b);
      send(OP_WRITE, fill_ptr, b, 1'b0, $urandom, $urandom, $urandom);
      fill_ptr++;
   endtask

   task automatic put_le(logic [63:0] v, int nbytes);
      for (int j = 0; j < nbytes; j++) put_byte(v[8*j +: 8]);
   endtask

   // Append a multi-entry node; hdr picks widths. Returns its end position.
   // mode: 0 well-formed, 1 random corruption in counts/offsets/size.
   task automatic build_node(logic [7:0] hdr_hi, int k, int mode, output logic [20:0] end_pos);
      int cw, ow, esize;
      logic [20:0] start;
      logic [63:0] off;
      logic [31:0] c;
      logic [7:0] hdr;
      cw = (hdr_hi < HDR_CNT2_LO) ? 1 : (hdr_hi < HDR_CNT4_LO) ? 2 : 4;
      ow = (hdr_hi < HDR_SINGLE_LO) ? 0 : (hdr_hi < HDR_OFF1_HI) ? 1 :
           (hdr_hi < HDR_CNT4_LO) ? 2 : 8;
      esize = cw + ow + 1;
      start = fill_ptr;
      for (int e = 0; e < k; e++) begin
         put_byte($urandom);
         c = $urandom_range(1, (cw == 1) ? 255 : (cw == 2) ? 65535 : 32'h7FFF_FFFF);
         if (mode == 1 && $urandom_range(0, 5) == 0) c = (cw == 4 && $urandom_range(0, 1)) ? 32'h8000_0000 | $urandom : 0;
         put_le(c, cw);
         if (ow > 0) begin
            if ($urandom_range(0, 3) == 0) off = '1;
            else if (start == 0) off = '1;
            else off = $urandom_range(0, start);
            if (mode == 1 && $urandom_range(0, 5) == 0) off = start + $urandom_range(1, 5);
            if (mode == 1 && ow == 8 && $urandom_range(0, 3) == 0) off = {$urandom, $urandom};
            put_le(off, ow);
         end
      end
      if (k >= 1 && k <= 31 && $urandom_range(0, 1)) hdr = hdr_hi | 8'(k);
      else begin
         put_byte(mode == 1 && $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'(k));
         hdr = hdr_hi;
      end
      put_byte(hdr);
      end_pos = fill_ptr;
      node_ends = {node_ends, fill_ptr};
   endtask

   task automatic decode(logic [20:0] pos, logic [31:0] cnt, logic [7:0] lo, logic [7:0] hi);
      send(OP_DECODE, pos, $urandom, 1'b0, cnt, lo, hi);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);  // let the sequencer settle back to idle
   endtask

   task automatic set_length(logic [20:0] len);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      valid_length = len;
   endtask

   function automatic logic [7:0] random_hdr_hi();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h80;
         2: return 8'hA0;
         3: return 8'hC0;
         4: return 8'hE0;
         default: return 8'($urandom_range(0, 7)) << 5 & 8'hE0;
      endcase
   endfunction

   initial begin
      logic [20:0] p;
      logic [7:0] lo, hi;
      int r;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_WRITE;
      req_bus.address = '0;
      req_bus.write_data = '0;
      req_bus.node_none = 1'b0;
      req_bus.running_count = '0;
      req_bus.min_symbol = '0;
      req_bus.max_symbol = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: special bytes at the very start of memory.
      put_byte(8'h41);            // single symbol at position 0: no room for child
      put_byte(8'h00);            // extended count header at 1 -> reads k=0x41
      send(OP_WRITE, 21'h1FFFFF, 8'hFF, 1'b0, 0, 0, 0);  // above memory, dropped
      set_length(21'd2);
      decode(21'd1, 32'h8000_0000, 8'h80, 8'h7F);   // single at end 1: need next
      decode(21'd2, 32'h7FFF_FFFF, 8'h80, 8'h7F);   // bad size
      decode(21'd0, 32'hFFFF_FFFF, 8'h80, 8'h7F);   // bad node at 0
      decode(21'd3, 32'd5, 8'h80, 8'h7F);           // above index length
      decode(21'h1FFFFF, 32'd5, 8'h80, 8'h7F);      // far above
      send(OP_DECODE, 21'd2, 0, 1'b1, 32'h1234_5678, 0, 0);  // empty sentinel
      // Small node, then single-symbol headers 0x7F and 0x20 at the end.
      wait_drained();
      build_node(8'h00, 1, 0, p);
      put_byte(8'h7F);
      put_byte(8'h20);
      set_length(fill_ptr);
      decode(fill_ptr, 32'd100, 8'h80, 8'h7F);
      decode(fill_ptr - 1, 32'd100, 8'h80, 8'h7F);
      decode(fill_ptr, 32'd100, 8'h7F, 8'h80);     // empty range
      foreach (node_ends[i]) decode(node_ends[i], $urandom, 8'h80, 8'h7F);
      build_node(8'h00, 63, 0, p);    // largest table allowed
      put_byte(8'd64);                // too many entries: rejected before the table
      put_byte(8'h80);
      node_ends = {node_ends, fill_ptr};
      for (int w = 0; w < 4; w++)
         build_node(8'h80 + 8'(w) * 8'h20, $urandom_range(1, 4), w % 2, p);
      build_node(8'hE0, 1, 0, p);
      set_length(fill_ptr);
      foreach (node_ends[i]) decode(node_ends[i], $urandom, 8'h80, 8'h7F);

      // Random phase; each round builds a few nodes then decodes them.
      for (int round = 0; round < 6; round++) begin
         node_ends.delete();
         for (int j = 0; j < 2; j++)
            build_node(random_hdr_hi(), $urandom_range(1, 3), ($urandom_range(0, 3) == 0), p);
         put_byte(8'($urandom_range(8'h20, 8'h7F)));
         node_ends = {node_ends, fill_ptr};
         if (round == 2) set_length(21'h1FFFFF);
         else if (round == 5) set_length(fill_ptr - 3);
         else set_length(fill_ptr);
         for (int j = 0; j < 6; j++) begin
            r = $urandom_range(0, 19);
            lo = $urandom;
            hi = $urandom;
            if ($urandom_range(0, 2) != 0) begin
               lo = 8'h80;
               hi = 8'h7F;
            end
            if (r == 0) send(OP_DECODE, $urandom, $urandom, 1'b1, $urandom, lo, hi);
            else if (r == 1 && valid_length <= fill_ptr)
               decode(fill_ptr + $urandom_range(1, 100), $urandom, lo, hi);
            else if (r == 2)
               decode(21'h100000 | 21'($urandom_range(1, 20'hFFFFF)), $urandom, lo, hi);
            else decode(node_ends[$urandom_range(0, node_ends.size() - 1)], $urandom, lo, hi);
         end
         if (round == 1) wait_drained();   // sender holds off until all responses are in
      end
      set_length(21'd0);
      decode(21'd1, 32'd9, 8'h80, 8'h7F);

      drop_valid();
      fork
         begin
            while (pending_count != 0) @(posedge clock);
            repeat (200) @(posedge clock);
         end
         begin
            repeat (200000) @(posedge clock);
            $display("drain timeout, %0d responses outstanding", pending_count);
         end
      join_any
      $display("covered %0d byte writes, %0d decodes, %0d response transactions",
               writes_sent, decodes_sent, rsp_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("trie_node_decoder regression: pass");
      else
         $display("trie_node_decoder regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("trie_node_decoder regression: fail");
      $finish;
   end
endmodule

// File: trie_node_decoder.f
sv/tnd_pkg.sv
sv/tnd_if.sv
sv/tnd_ram.sv
sv/trie_node_decoder.sv
verif/tnd_checker.sv
verif/trie_node_decoder_tb.sv
